// ===== sv/fpd_pkg.sv =====
// Shared constants and types for the frame pacing delay block.
`default_nettype none

package fpd_pkg;

    // Width of timing values (elapsed time and target period).
    localparam int TIME_BITS = 40;
    // Width of the lateness and lag accumulators.
    localparam int ACC_BITS  = 48;
    // Divider steps: one quotient bit per step over the accumulator width.
    localparam int DIV_STEPS = ACC_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_STEPS - 1);

    localparam logic [TIME_BITS-1:0] TARGET_RESET = TIME_BITS'(16666666);
    localparam logic [ACC_BITS-1:0]  ACC_MAX      = {ACC_BITS{1'b1}};

    // Configuration port geometry: 64-bit registers at 8-byte spacing.
    localparam int APB_DATA_BITS = 64;
    localparam int APB_ADDR_BITS = 4;
    localparam logic REG_TARGET  = 1'b0;

    // Result status codes.
    localparam logic STATUS_WAITED = 1'b0;
    localparam logic STATUS_LATE   = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ACCUM,
        ST_MOD,
        ST_WAIT,
        ST_EXCESS,
        ST_LAG,
        ST_DROP,
        ST_DONE
    } fpd_state_t;

endpackage

`default_nettype wire

// ===== sv/frame_pacing_delay.sv =====
// Frame pacer: wait time per frame, late-frame accounting and dropped-frame count.
// Each frame runs through the shared restoring divider (48 steps per division): one
// division for an on-time or late frame, two when pending lateness is resolved; a stalled
// result register adds its wait. One transaction at a time: s_tready is high only when
// idle, so a new frame is taken only after the last result is loaded into the result
// register. Reset: async active-low, accumulators clear.
`default_nettype none

module frame_pacing_delay (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Input stream
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [fpd_pkg::TIME_BITS-1:0]          s_tdata,   // [39:0] elapsed_ns
    // Result stream
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [fpd_pkg::TIME_BITS+fpd_pkg::ACC_BITS-1:0] m_tdata, // [39:0] wait_ns,
                                                                     // [87:40] dropped_frames
    output logic [0:0]                                  m_tuser,   // [0] status
    // Configuration port
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [fpd_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  wire logic [fpd_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic [fpd_pkg::APB_DATA_BITS-1:0]           prdata,
    output logic                                        pready
);

    localparam int TB = fpd_pkg::TIME_BITS;
    localparam int AB = fpd_pkg::ACC_BITS;

    fpd_pkg::fpd_state_t state_reg, state_next;

    logic [TB-1:0]                target_reg;
    logic [AB-1:0]                late_accum_reg, late_accum_next;
    logic [AB-1:0]                total_lag_reg,  total_lag_next;
    logic [TB-1:0]                elapsed_reg,    elapsed_next;
    logic                         status_reg,     status_next;
    logic [TB-1:0]                wait_reg,       wait_next;
    logic [AB-1:0]                excess_reg,     excess_next;
    logic [AB-1:0]                quo_reg,        quo_next;
    logic [TB-1:0]                rem_reg,        rem_next;
    logic [fpd_pkg::CNT_BITS-1:0] cnt_reg,        cnt_next;

    logic                         m_tvalid_reg,   m_tvalid_next;
    logic                         out_status_reg;
    logic [TB-1:0]                out_wait_reg;
    logic [AB-1:0]                out_drop_reg;

    logic                         in_xact;
    logic                         load_out;
    logic                         cfg_write;

    // Shared datapath signals
    logic                         is_late;
    logic [TB:0]                  trial;
    logic [TB+1:0]                trial_diff;
    logic                         trial_ge;
    logic [TB-1:0]                rem_step;
    logic [AB-1:0]                quo_step;
    logic [AB-1:0]                add_a, add_b;
    logic [AB:0]                  add_sum;
    logic [AB-1:0]                sat_sum;
    logic [AB:0]                  excess_diff;
    logic                         excess_pos;

    // Configuration access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[3] == fpd_pkg::REG_TARGET);
    assign prdata    = (paddr[3] == fpd_pkg::REG_TARGET)
                       ? {{(fpd_pkg::APB_DATA_BITS-TB){1'b0}}, target_reg}
                       : '0;

    // Handshake decode
    always_comb
    begin
        s_tready = (state_reg == fpd_pkg::ST_IDLE);
        load_out = (state_reg == fpd_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);
    end

    assign in_xact = s_tvalid && s_tready;

    // Drive result ports from the output register
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {out_drop_reg, out_wait_reg};
    assign m_tuser[0] = out_status_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpd_pkg::ST_IDLE:
            begin
                if (in_xact)
                begin
                    state_next = fpd_pkg::ST_EVAL;
                end
            end
            fpd_pkg::ST_EVAL:
            begin
                if (is_late)
                begin
                    state_next = fpd_pkg::ST_ACCUM;
                end
                else if (late_accum_reg != '0)
                begin
                    state_next = fpd_pkg::ST_MOD;
                end
                else
                begin
                    state_next = fpd_pkg::ST_DROP;
                end
            end
            fpd_pkg::ST_ACCUM:  state_next = fpd_pkg::ST_DROP;
            fpd_pkg::ST_MOD:
            begin
                if (cnt_reg == fpd_pkg::CNT_LAST)
                begin
                    state_next = fpd_pkg::ST_WAIT;
                end
            end
            fpd_pkg::ST_WAIT:   state_next = fpd_pkg::ST_EXCESS;
            fpd_pkg::ST_EXCESS: state_next = fpd_pkg::ST_LAG;
            fpd_pkg::ST_LAG:    state_next = fpd_pkg::ST_DROP;
            fpd_pkg::ST_DROP:
            begin
                if (cnt_reg == fpd_pkg::CNT_LAST)
                begin
                    state_next = fpd_pkg::ST_DONE;
                end
            end
            fpd_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = fpd_pkg::ST_IDLE;
                end
            end
            default:            state_next = fpd_pkg::ST_IDLE;
        endcase
    end

    // Shared units: one restoring divider step, one saturating adder
    always_comb
    begin
        is_late    = (elapsed_reg >= target_reg);

        trial      = {rem_reg, quo_reg[AB-1]};
        trial_diff = {1'b0, trial} - {2'b00, target_reg};
        trial_ge   = !trial_diff[TB+1];
        rem_step   = trial_ge ? trial_diff[TB-1:0] : trial[TB-1:0];
        quo_step   = {quo_reg[AB-2:0], trial_ge};

        if (state_reg == fpd_pkg::ST_ACCUM)
        begin
            add_a = late_accum_reg;
            add_b = {{(AB-TB){1'b0}}, elapsed_reg};
        end
        else
        begin
            add_a = total_lag_reg;
            add_b = excess_reg;
        end
        add_sum = {1'b0, add_a} + {1'b0, add_b};
        sat_sum = add_sum[AB] ? fpd_pkg::ACC_MAX : add_sum[AB-1:0];

        excess_diff = {1'b0, late_accum_reg} - {{(AB-TB+1){1'b0}}, target_reg};
        excess_pos  = !excess_diff[AB] && (excess_diff[AB-1:0] != '0);
    end

    // Datapath next values
    always_comb
    begin
        late_accum_next = late_accum_reg;
        total_lag_next  = total_lag_reg;
        elapsed_next    = elapsed_reg;
        status_next     = status_reg;
        wait_next       = wait_reg;
        excess_next     = excess_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;

        case (state_reg)
            fpd_pkg::ST_IDLE:
            begin
                if (in_xact)
                begin
                    elapsed_next = s_tdata;
                end
            end
            fpd_pkg::ST_EVAL:
            begin
                // Classify the frame and pick the wait path
                status_next = is_late ? fpd_pkg::STATUS_LATE : fpd_pkg::STATUS_WAITED;
                if (is_late)
                begin
                    wait_next = '0;
                end
                else if (late_accum_reg != '0)
                begin
                    quo_next = late_accum_reg;
                    rem_next = '0;
                    cnt_next = '0;
                end
                else
                begin
                    wait_next = target_reg - elapsed_reg;
                    quo_next  = total_lag_reg;
                    rem_next  = '0;
                    cnt_next  = '0;
                end
            end
            fpd_pkg::ST_ACCUM:
            begin
                // Add elapsed time to pending lateness, then start drop division
                late_accum_next = sat_sum;
                quo_next        = total_lag_reg;
                rem_next        = '0;
                cnt_next        = '0;
            end
            fpd_pkg::ST_MOD,
            fpd_pkg::ST_DROP:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
            end
            fpd_pkg::ST_WAIT:
            begin
                // Realign to the period grid
                wait_next = target_reg - rem_reg;
            end
            fpd_pkg::ST_EXCESS:
            begin
                excess_next = excess_pos ? excess_diff[AB-1:0] : '0;
            end
            fpd_pkg::ST_LAG:
            begin
                // Fold excess into total lag and clear pending lateness
                total_lag_next  = sat_sum;
                late_accum_next = '0;
                quo_next        = sat_sum;
                rem_next        = '0;
                cnt_next        = '0;
            end
            fpd_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fpd_pkg::ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            target_reg     <= fpd_pkg::TARGET_RESET;
            late_accum_reg <= '0;
            total_lag_reg  <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            late_accum_reg <= late_accum_next;
            total_lag_reg  <= total_lag_next;
            cnt_reg        <= cnt_next;
            if (cfg_write)
            begin
                target_reg <= pwdata[TB-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        elapsed_reg <= elapsed_next;
        status_reg  <= status_next;
        wait_reg    <= wait_next;
        excess_reg  <= excess_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_wait_reg   <= wait_reg;
            out_drop_reg   <= (target_reg == '0) ? '0 : quo_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // A new result appears only as the sequencer leaves its final state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == fpd_pkg::ST_DONE))
        else $error("result presented outside the completion state");

    // A late frame never carries a wait
    a_late_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[0] == fpd_pkg::STATUS_LATE)) |-> (m_tdata[TB-1:0] == '0))
        else $error("late frame reports a nonzero wait");

    // An on-time frame always waits at least one nanosecond
    a_ontime_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[0] == fpd_pkg::STATUS_WAITED)) |-> (m_tdata[TB-1:0] != '0))
        else $error("on-time frame reports a zero wait");

    // Divider step count stays within one division
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == fpd_pkg::ST_MOD) || (state_reg == fpd_pkg::ST_DROP))
        |-> (cnt_reg <= fpd_pkg::CNT_LAST))
        else $error("divider step count out of range");
`endif

endmodule

`default_nettype wire

// ===== test/frame_pacing_checker.sv =====
// Checker for the frame pacer: tracks the pacing state, predicts each result and compares.
module frame_pacing_checker (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            s_tvalid,
    input  logic                                            s_tready,
    input  logic [fpd_pkg::TIME_BITS-1:0]                   s_tdata,   // [39:0] elapsed_ns
    input  logic                                            m_tvalid,
    input  logic                                            m_tready,
    input  logic [fpd_pkg::TIME_BITS+fpd_pkg::ACC_BITS-1:0] m_tdata,   // [39:0] wait_ns,
                                                                       // [87:40] dropped_frames
    input  logic [0:0]                                      m_tuser,   // [0] status
    input  logic                                            psel,
    input  logic                                            penable,
    input  logic                                            pwrite,
    input  logic [fpd_pkg::APB_ADDR_BITS-1:0]               paddr,
    input  logic [fpd_pkg::APB_DATA_BITS-1:0]               pwdata,
    input  logic                                            pready,
    output int                                              mismatches,
    output int                                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_BITS     = fpd_pkg::TIME_BITS;
    localparam int ACC_BITS      = fpd_pkg::ACC_BITS;
    localparam int APB_ADDR_BITS = fpd_pkg::APB_ADDR_BITS;

    localparam logic [APB_ADDR_BITS-1:0] TARGET_ADDR = APB_ADDR_BITS'(8 * fpd_pkg::REG_TARGET);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                 status;
        logic [TIME_BITS-1:0] wait_ns;
        logic [ACC_BITS-1:0]  dropped;
    } pace_result_t;

    // Shadow of the block's configuration and accounting state
    logic [TIME_BITS-1:0] target_q;
    logic [ACC_BITS-1:0]  late_accum_q;
    logic [ACC_BITS-1:0]  total_lag_q;
    pace_result_t         pace_results_q[$];
    int                   fail_count;

    // Add with saturation at the accumulator maximum
    function automatic logic [ACC_BITS-1:0] sat_accumulate(input logic [ACC_BITS-1:0] acc,
                                                           input logic [63:0] addend);
        logic [64:0] sum;
        sum = 65'(acc) + 65'(addend);
        return (sum > 65'(fpd_pkg::ACC_MAX)) ? fpd_pkg::ACC_MAX : sum[ACC_BITS-1:0];
    endfunction

    // Work out one pacing step and advance the shadow state
    task automatic pace_frame(input logic [TIME_BITS-1:0] elapsed, output pace_result_t res);
        logic [ACC_BITS-1:0] target_w;
        logic [ACC_BITS-1:0] phase_err;
        target_w    = ACC_BITS'(target_q);
        res.status  = fpd_pkg::STATUS_WAITED;
        res.wait_ns = '0;
        if (elapsed >= target_q)
        begin
            late_accum_q = sat_accumulate(late_accum_q, 64'(elapsed));
            res.status   = fpd_pkg::STATUS_LATE;
        end
        else
        begin
            if (late_accum_q != '0)
            begin
                // realign to the period grid; book only the excess beyond one period
                phase_err   = late_accum_q % target_w;
                res.wait_ns = TIME_BITS'(target_w - phase_err);
                if (late_accum_q > target_w)
                    total_lag_q = sat_accumulate(total_lag_q, 64'(late_accum_q - target_w));
            end
            else
            begin
                res.wait_ns = target_q - elapsed;
            end
            late_accum_q = '0;
        end
        res.dropped = (target_q != '0) ? total_lag_q / target_w : '0;
    endtask

    task automatic report_mismatch(input pace_result_t exp_r, input pace_result_t got_r);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display({"mismatch %0d at %0t: expected status %0d wait %0d dropped %0d,",
                      " got status %0d wait %0d dropped %0d"},
                     fail_count, $realtime, exp_r.status, exp_r.wait_ns, exp_r.dropped,
                     got_r.status, got_r.wait_ns, got_r.dropped);
    endtask

    // Watch configuration, input and result channels
    always @(posedge clk or negedge rst_n)
    begin
        pace_result_t exp_r;
        pace_result_t got_r;
        if (!rst_n)
        begin
            target_q     = fpd_pkg::TARGET_RESET;
            late_accum_q = '0;
            total_lag_q  = '0;
            fail_count   = 0;
            pace_results_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // capture register writes
            if (psel && penable && pwrite && pready && paddr == TARGET_ADDR)
                target_q = pwdata[TIME_BITS-1:0];
            // predict each accepted transaction
            if (s_tvalid && s_tready)
            begin
                pace_frame(s_tdata, exp_r);
                pace_results_q.push_back(exp_r);
            end
            // compare each accepted result with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got_r.status  = m_tuser[0];
                got_r.wait_ns = m_tdata[TIME_BITS-1:0];
                got_r.dropped = m_tdata[TIME_BITS +: ACC_BITS];
                if (pace_results_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"mismatch %0d at %0t: unexpected result",
                                  " status %0d wait %0d dropped %0d"},
                                 fail_count, $realtime, got_r.status, got_r.wait_ns,
                                 got_r.dropped);
                end
                else
                begin
                    exp_r = pace_results_q.pop_front();
                    if (got_r !== exp_r)
                        report_mismatch(exp_r, got_r);
                end
            end
            mismatches  <= fail_count;
            outstanding <= pace_results_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the frame pacer: clock, reset, stimulus, receiver stalls and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_BITS     = fpd_pkg::TIME_BITS;
    localparam int ACC_BITS      = fpd_pkg::ACC_BITS;
    localparam int APB_ADDR_BITS = fpd_pkg::APB_ADDR_BITS;
    localparam int APB_DATA_BITS = fpd_pkg::APB_DATA_BITS;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 120;
    localparam int PHASE_ITEMS     = 40;
    localparam int SAT_LATE_FRAMES = 260;
    localparam int TIMEOUT_NS      = 6_000_000;

    localparam logic [APB_ADDR_BITS-1:0] TARGET_ADDR   =
        APB_ADDR_BITS'(8 * fpd_pkg::REG_TARGET);
    localparam logic [APB_ADDR_BITS-1:0] UNMAPPED_ADDR = APB_ADDR_BITS'(8);
    localparam logic [TIME_BITS-1:0]     TIME_MAX      = {TIME_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0]     TARGET_RESET  = fpd_pkg::TARGET_RESET;

    typedef enum int {SEQ_ON_TIME, SEQ_LATE_RUN, SEQ_BOUNDARY, SEQ_NOISE} frame_seq_t;
    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [TIME_BITS-1:0]          s_tdata;    // [39:0] elapsed_ns
    logic                          m_tvalid;
    logic                          m_tready;
    logic [TIME_BITS+ACC_BITS-1:0] m_tdata;    // [39:0] wait_ns, [87:40] dropped_frames
    logic [0:0]                    m_tuser;    // [0] status
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [APB_ADDR_BITS-1:0]      paddr;
    logic [APB_DATA_BITS-1:0]      pwdata;
    logic [APB_DATA_BITS-1:0]      prdata;
    logic                          pready;
    int                            mismatches;
    int                            outstanding;

    int                            burst_left = 0;
    bit                            hold_off_req = 1'b0;
    bit                            hold_off_done = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    frame_pacing_delay DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    frame_pacing_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic logic [TIME_BITS-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_BITS-1:0];
    endfunction

    // Uniform value in [0, bound), bound nonzero
    function automatic logic [TIME_BITS-1:0] rand_below(input logic [TIME_BITS-1:0] bound);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return TIME_BITS'(r % 64'(bound));
    endfunction

    // Late elapsed time: within one extra period about half the time, otherwise anywhere from target to the maximum
    function automatic logic [TIME_BITS-1:0] rand_late(input logic [TIME_BITS-1:0] target);
        logic [63:0] span;
        logic [63:0] reach;
        logic [63:0] r;
        span  = 64'(TIME_MAX) - 64'(target) + 64'd1;
        reach = ($urandom_range(0, 1) == 1 && 64'(target) < span) ? 64'(target) : span;
        r     = {$urandom, $urandom};
        return TIME_BITS'(64'(target) + r % reach);
    endfunction

    // Offer one transaction, with bursts and random gaps between them
    task automatic send_frame(input logic [TIME_BITS-1:0] elapsed);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= elapsed;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reprogram the target period once idle; junk in the upper bus bits must be dropped
    task automatic set_target(input logic [TIME_BITS-1:0] target);
        logic [APB_DATA_BITS-TIME_BITS-1:0] junk;
        junk = (APB_DATA_BITS-TIME_BITS)'($urandom);
        drain();
        write_reg(TARGET_ADDR, {junk, target});
    endtask

    // Mostly well-formed frame sequences, some boundary hits and noise
    task automatic run_pacing_phase(input logic [TIME_BITS-1:0] target, input int n_items);
        int         count;
        int         run_len;
        int         pick;
        frame_seq_t kind;
        set_target(target);
        count = 0;
        while (count < n_items)
        begin
            pick = $urandom_range(0, 9);
            kind = (pick < 5) ? SEQ_ON_TIME : (pick < 8) ? SEQ_LATE_RUN :
                   (pick < 9) ? SEQ_BOUNDARY : SEQ_NOISE;
            case (kind)
                SEQ_ON_TIME:
                begin
                    send_frame(rand_below(target));
                    count++;
                end
                SEQ_LATE_RUN:
                begin
                    run_len = $urandom_range(1, 4);
                    repeat (run_len) send_frame(rand_late(target));
                    send_frame(rand_below(target));
                    count += run_len + 1;
                end
                SEQ_BOUNDARY:
                begin
                    send_frame(($urandom_range(0, 1) == 1) ? target : target - 1'b1);
                    count++;
                end
                default:
                begin
                    send_frame(rand_time());
                    count++;
                end
            endcase
        end
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        logic [TIME_BITS-1:0] target;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        rst_n    <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset target: on-time, edges of the period, late run, then resolve
        send_frame('0);
        send_frame(TARGET_RESET - 1'b1);
        send_frame(TARGET_RESET);
        send_frame(TARGET_RESET + 1'b1);
        send_frame('0);
        send_frame(TIME_MAX);
        send_frame(40'hAA_AAAA_AAAA);
        send_frame(40'h55_5555_5555);
        send_frame(40'd12345);

        // smallest target: only zero elapsed is on time
        set_target(40'd1);
        send_frame('0);
        send_frame(40'd1);
        send_frame(TIME_MAX);
        send_frame('0);

        // largest target: pending lateness exactly one period adds no lag
        set_target(TIME_MAX);
        send_frame(TIME_MAX);
        send_frame('0);
        send_frame(TIME_MAX - 1'b1);

        // write to an unmapped register must leave the target alone
        drain();
        write_reg(UNMAPPED_ADDR, APB_DATA_BITS'(5));
        send_frame(40'd5);

        // pending lateness below one period after raising the target
        set_target(40'd1000);
        send_frame(40'd1500);
        set_target(40'd5000);
        send_frame(40'd10);

        // random phases over several targets; long receiver hold-off in the first
        set_target(TARGET_RESET);
        hold_off_req = 1'b1;
        run_pacing_phase(TARGET_RESET, PHASE_ITEMS);
        run_pacing_phase(TIME_BITS'($urandom_range(2, 5000)), PHASE_ITEMS);
        target = rand_time();
        if (target == '0) target = 40'd1;
        run_pacing_phase(target, PHASE_ITEMS);
        run_pacing_phase(TIME_BITS'($urandom_range(100_000, 100_000_000)), PHASE_ITEMS);

        // saturate the late accumulator, then the total lag
        target = TIME_BITS'($urandom_range(1000, 1 << 30));
        set_target(target);
        repeat (SAT_LATE_FRAMES) send_frame(TIME_MAX - TIME_BITS'($urandom_range(0, 1023)));
        send_frame(rand_below(target));
        repeat (2) send_frame(rand_late(target));
        send_frame(rand_below(target));
        repeat (3) send_frame(rand_below(target));

        // let stray results show up, then decide
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS frame_pacing_delay");
        else
            $display("FAIL frame_pacing_delay");
        $finish;
    end

    // Receiver: segments of steady, coin-flip and sparse ready, plus one long hold-off
    initial
    begin : receiver
        int          seg_len;
        ready_mode_t mode;
        m_tready <= 1'b0;
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else
            begin
                seg_len = $urandom_range(10, 60);
                mode    = ready_mode_t'($urandom_range(0, 2));
                repeat (seg_len)
                begin
                    case (mode)
                        READY_ALWAYS: m_tready <= 1'b1;
                        READY_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
                        default:      m_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL frame_pacing_delay");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/fpd_pkg.sv
sv/frame_pacing_delay.sv
test/frame_pacing_checker.sv
test/tb.sv
